>>> rtl/yuvrgb_pkg.sv
// ---------------------------------------------------------------------------
// yuvrgb_pkg: shared types, constants and helpers
// Register indexes, coefficient defaults, lane and chroma result types, and
// the per-channel clamp and pixel packing used by the lanes and the merge.
// ---------------------------------------------------------------------------
`default_nettype none

package yuvrgb_pkg;

    // Field and port widths
    localparam int unsigned SampleW = 8;
    localparam int unsigned CoefW   = 16;
    localparam int unsigned PixelW  = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned TermW   = 12;   // floor(a*c/65536) of one term

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_OUTPUT_FORMAT = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_LUMA_GAIN     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_U_TO_BLUE     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_U_TO_GREEN    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_V_TO_RED      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_V_TO_GREEN    = 3'd5;

    // Output format codes
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_XRGB32 = 1'b1;

    // Reset values of the coefficients (signed Q13)
    localparam logic signed [CoefW-1:0] DEF_LUMA_GAIN  = 16'sd9535;
    localparam logic signed [CoefW-1:0] DEF_U_TO_BLUE  = 16'sd16531;
    localparam logic signed [CoefW-1:0] DEF_U_TO_GREEN = -16'sd3203;
    localparam logic signed [CoefW-1:0] DEF_V_TO_RED   = 16'sd13074;
    localparam logic signed [CoefW-1:0] DEF_V_TO_GREEN = -16'sd6660;

    // Luma black level
    localparam logic [SampleW-1:0] LUMA_OFFSET = 8'd16;

    // Chroma contributions shared by both lanes
    typedef struct packed {
        logic signed [TermW-1:0] cb;
        logic signed [TermW-1:0] cg;
        logic signed [TermW-1:0] cr;
    } t_chroma;

    // One converted pixel
    typedef struct packed {
        logic [SampleW-1:0] r;
        logic [SampleW-1:0] g;
        logic [SampleW-1:0] b;
    } t_rgb;

    // Add chroma term and luma term, clamp to 0..255. Both terms stay within
    // 12 bits, so their 13-bit sum can never overflow.
    function automatic logic [SampleW-1:0] clamp_chan(
        input logic signed [TermW-1:0] c,
        input logic signed [TermW-1:0] l
    );
        logic signed [TermW:0] s;
        s = $signed({c[TermW-1], c}) + $signed({l[TermW-1], l});
        if (s < 0) begin
            clamp_chan = '0;
        end else if (s > $signed({1'b0, {(TermW-SampleW){1'b0}}, {SampleW{1'b1}}})) begin
            clamp_chan = {SampleW{1'b1}};
        end else begin
            clamp_chan = s[SampleW-1:0];
        end
    endfunction

    // Pack one pixel as RGB565 in the low half or as 0x00RRGGBB
    function automatic logic [PixelW-1:0] pack_pixel(input t_rgb p, input logic fmt);
        if (fmt == FMT_XRGB32) begin
            pack_pixel = {8'h00, p.r, p.g, p.b};
        end else begin
            pack_pixel = {16'h0000, p.r[7:3], p.g[7:2], p.b[7:3]};
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/yuvrgb_chroma.sv
// ---------------------------------------------------------------------------
// yuvrgb_chroma: shared chroma unit
// Centers U and V, scales them by 8, multiplies by the four chroma
// coefficients and keeps the floor of the high half of each product.
// Two register stages: products, then terms.
// ---------------------------------------------------------------------------
`default_nettype none

module yuvrgb_chroma (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en_mul,
    input  wire logic                                   i_en_sum,
    input  wire logic [yuvrgb_pkg::SampleW-1:0]         i_u,
    input  wire logic [yuvrgb_pkg::SampleW-1:0]         i_v,
    input  wire logic signed [yuvrgb_pkg::CoefW-1:0]    i_u_to_blue,
    input  wire logic signed [yuvrgb_pkg::CoefW-1:0]    i_u_to_green,
    input  wire logic signed [yuvrgb_pkg::CoefW-1:0]    i_v_to_red,
    input  wire logic signed [yuvrgb_pkg::CoefW-1:0]    i_v_to_green,
    output yuvrgb_pkg::t_chroma                         o_chroma
);
    import yuvrgb_pkg::*;

    localparam int unsigned CW = SampleW + 3;     // centered sample times 8
    localparam int unsigned PW = CW + CoefW;      // product width

    logic signed [CW-1:0] cu;
    logic signed [CW-1:0] cv;
    logic signed [PW-1:0] r_pb, r_pug, r_pvg, r_pr;
    logic signed [PW-1:0] n_pb, n_pug, n_pvg, n_pr;
    t_chroma              r_chroma;
    t_chroma              n_chroma;

    // Center on 128 by flipping the top bit, then scale by 8
    assign cu = $signed({~i_u[SampleW-1], i_u[SampleW-2:0], 3'b000});
    assign cv = $signed({~i_v[SampleW-1], i_v[SampleW-2:0], 3'b000});

    assign n_pb  = cu * i_u_to_blue;
    assign n_pug = cu * i_u_to_green;
    assign n_pvg = cv * i_v_to_green;
    assign n_pr  = cv * i_v_to_red;

    // Keep the floor of each product over 65536 and sum the green pair
    always_comb begin
        n_chroma.cb = $signed({r_pb[PW-1], r_pb[PW-1:16]});
        n_chroma.cr = $signed({r_pr[PW-1], r_pr[PW-1:16]});
        n_chroma.cg = $signed({r_pug[PW-1], r_pug[PW-1:16]})
                    + $signed({r_pvg[PW-1], r_pvg[PW-1:16]});
    end

    // Advance the product stage
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_pb  <= n_pb;
            r_pug <= n_pug;
            r_pvg <= n_pvg;
            r_pr  <= n_pr;
        end
    end

    // Advance the term stage
    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_chroma <= n_chroma;
        end
    end

    assign o_chroma = r_chroma;

endmodule

`default_nettype wire

>>> rtl/yuvrgb_lane.sv
// ---------------------------------------------------------------------------
// yuvrgb_lane: one luma lane
// Removes the black level, scales by 8, applies the luma gain and keeps the
// floor of the high half. The registered luma term is then added to the
// shared chroma terms and clamped per channel.
// ---------------------------------------------------------------------------
`default_nettype none

module yuvrgb_lane (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en_mul,
    input  wire logic                                   i_en_sum,
    input  wire logic [yuvrgb_pkg::SampleW-1:0]         i_y,
    input  wire logic signed [yuvrgb_pkg::CoefW-1:0]    i_luma_gain,
    input  wire yuvrgb_pkg::t_chroma                    i_chroma,
    output yuvrgb_pkg::t_rgb                            o_rgb
);
    import yuvrgb_pkg::*;

    localparam int unsigned LW = SampleW + 4;     // offset luma times 8, plus sign
    localparam int unsigned PW = LW + CoefW;

    logic [SampleW-1:0]      yo;
    logic signed [LW-1:0]    ys;
    logic signed [PW-1:0]    r_prod;
    logic signed [PW-1:0]    n_prod;
    logic signed [TermW-1:0] r_lum;

    // Subtract the black level with a floor at zero
    assign yo = (i_y > LUMA_OFFSET) ? (i_y - LUMA_OFFSET) : '0;
    assign ys = $signed({1'b0, yo, 3'b000});

    assign n_prod = ys * i_luma_gain;

    // Advance the product stage
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod <= n_prod;
        end
    end

    // Keep the floor of the product over 65536
    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_lum <= r_prod[PW-1:16];
        end
    end

    // Combine with the chroma terms
    always_comb begin
        o_rgb.r = clamp_chan(i_chroma.cr, r_lum);
        o_rgb.g = clamp_chan(i_chroma.cg, r_lum);
        o_rgb.b = clamp_chan(i_chroma.cb, r_lum);
    end

endmodule

`default_nettype wire

>>> rtl/yuv_to_rgb_pixel_pair_top.sv
// ---------------------------------------------------------------------------
// yuv_to_rgb_pixel_pair_top: YCbCr 4:2:2 pixel pair to RGB converter
// Input stream s_axis carries two luma samples with their shared U and V;
// output stream m_axis carries the two packed pixels. One transfer in
// gives one transfer out.
// Structure: a shared chroma unit and two luma lanes run side by side,
// each with a product stage and a term stage; the merge stage clamps,
// packs and holds the result in the output register.
// Path: an input transfer passes the product, term and output registers.
// Throughput: one pixel pair per cycle while m_axis is not stalled, set
// by the combinational multipliers in each lane and in the chroma unit.
// Stalls: every stage keeps its own valid bit and loads when it is empty
// or when the stage after it moves, so input is still taken while a
// result waits, until all three stages are full.
// Configuration: writes on i_cfg_* take effect at once; write only while
// the pipeline is empty. Reset (synchronous, active low) empties the
// pipeline and loads the BT.601 coefficients and RGB565 format.
// ---------------------------------------------------------------------------
`default_nettype none

module yuv_to_rgb_pixel_pair_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input pixel pair
    input  wire logic                                   s_axis_tvalid,
    output      logic                                   s_axis_tready,
    // [7:0] y_even, [15:8] y_odd, [23:16] u_sample, [31:24] v_sample
    input  wire logic [4*yuvrgb_pkg::SampleW-1:0]       s_axis_tdata,
    // output pixel pair
    output      logic                                   m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // [31:0] pixel_first, [63:32] pixel_second
    output      logic [2*yuvrgb_pkg::PixelW-1:0]        m_axis_tdata,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [yuvrgb_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  wire logic [yuvrgb_pkg::CoefW-1:0]           i_cfg_data
);
    import yuvrgb_pkg::*;

    // Configuration registers
    logic                    r_fmt;
    logic signed [CoefW-1:0] r_luma_gain;
    logic signed [CoefW-1:0] r_u_to_blue;
    logic signed [CoefW-1:0] r_u_to_green;
    logic signed [CoefW-1:0] r_v_to_red;
    logic signed [CoefW-1:0] r_v_to_green;

    // Pipeline control
    logic r_v1, r_v2, r_vo;
    logic en1, en2, en3;

    t_chroma                   chroma;
    t_rgb                      rgb_even;
    t_rgb                      rgb_odd;
    logic [2*PixelW-1:0]       r_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= FMT_RGB565;
            r_luma_gain  <= DEF_LUMA_GAIN;
            r_u_to_blue  <= DEF_U_TO_BLUE;
            r_u_to_green <= DEF_U_TO_GREEN;
            r_v_to_red   <= DEF_V_TO_RED;
            r_v_to_green <= DEF_V_TO_GREEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUTPUT_FORMAT: r_fmt        <= i_cfg_data[0];
                REG_LUMA_GAIN:     r_luma_gain  <= $signed(i_cfg_data);
                REG_U_TO_BLUE:     r_u_to_blue  <= $signed(i_cfg_data);
                REG_U_TO_GREEN:    r_u_to_green <= $signed(i_cfg_data);
                REG_V_TO_RED:      r_v_to_red   <= $signed(i_cfg_data);
                REG_V_TO_GREEN:    r_v_to_green <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Load a stage when it is empty or its contents move on
    assign en3 = !r_vo || m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_vo <= r_v2;
        end
    end

    yuvrgb_chroma u_chroma (
        .i_clk        (i_clk),
        .i_en_mul     (en1),
        .i_en_sum     (en2),
        .i_u          (s_axis_tdata[3*SampleW-1:2*SampleW]),
        .i_v          (s_axis_tdata[4*SampleW-1:3*SampleW]),
        .i_u_to_blue  (r_u_to_blue),
        .i_u_to_green (r_u_to_green),
        .i_v_to_red   (r_v_to_red),
        .i_v_to_green (r_v_to_green),
        .o_chroma     (chroma)
    );

    yuvrgb_lane u_lane_even (
        .i_clk       (i_clk),
        .i_en_mul    (en1),
        .i_en_sum    (en2),
        .i_y         (s_axis_tdata[SampleW-1:0]),
        .i_luma_gain (r_luma_gain),
        .i_chroma    (chroma),
        .o_rgb       (rgb_even)
    );

    yuvrgb_lane u_lane_odd (
        .i_clk       (i_clk),
        .i_en_mul    (en1),
        .i_en_sum    (en2),
        .i_y         (s_axis_tdata[2*SampleW-1:SampleW]),
        .i_luma_gain (r_luma_gain),
        .i_chroma    (chroma),
        .o_rgb       (rgb_odd)
    );

    // Merge: pack both pixels into the output register
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out <= {pack_pixel(rgb_odd, r_fmt), pack_pixel(rgb_even, r_fmt)};
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_out;

    // Input is refused only when every stage holds a pair
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_vo))
        else $error("input refused with an empty stage");

    // RGB565 leaves the upper half of both pixels clear
    a_rgb565_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && (r_fmt == FMT_RGB565)) |->
            (r_out[PixelW-1:16] == '0 && r_out[2*PixelW-1:PixelW+16] == '0))
        else $error("RGB565 result has upper bits set");

    // A result appears only from a filled term stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_v2))
        else $error("output valid without a pair in the term stage");

    // A pair in the term stage stays put while the stages after it stall
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en2) |=> r_v2)
        else $error("term stage dropped a pair under stall");

endmodule

`default_nettype wire
